// ===== rtl/core/badq_pkg.sv =====
package badq_pkg;

    // Default capacity and fixed field widths
    localparam int BADQ_DEPTH = 256;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 9;
    localparam int ECNT_W     = 9;

    // Request codes
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_GET        = 3'd2,
        REQ_FIND       = 3'd3,
        REQ_POP_FRONT  = 3'd4
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    // Per-cell update controls
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/badq_cell.sv =====
module badq_cell (
    input  logic                          clk,
    input  badq_pkg::cell_ctrl_t          ctrl,
    input  logic [badq_pkg::DATA_W-1:0]   ins_value,
    input  logic [badq_pkg::DATA_W-1:0]   prev_data,
    input  logic [badq_pkg::DATA_W-1:0]   next_data,
    input  logic [badq_pkg::DATA_W-1:0]   key,
    output logic [badq_pkg::DATA_W-1:0]   data,
    output logic                          match
);
    import badq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Move up, move down, take the new value or hold
    always_comb
    begin
        if (ctrl.shift_down)
        begin
            data_next = next_data;
        end
        else if (ctrl.shift_up)
        begin
            data_next = prev_data;
        end
        else if (ctrl.load)
        begin
            data_next = ins_value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Local compare against the search key
    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

// ===== rtl/core/badq_tree.sv =====
module badq_tree #(
    parameter int DEPTH = badq_pkg::BADQ_DEPTH
) (
    input  logic                                clk,
    input  logic [DEPTH-1:0]                    leaf_hit,
    input  logic [badq_pkg::DATA_W-1:0]         leaf_data [DEPTH],
    output logic                                root_hit,
    output logic [$clog2(DEPTH)-1:0]            root_pos,
    output logic [badq_pkg::DATA_W-1:0]         root_data
);
    import badq_pkg::*;

    localparam int PW     = $clog2(DEPTH);
    localparam int LEAVES = 1 << PW;
    localparam int NODES  = 2 * LEAVES;

    logic [LEAVES-1:0] pad_hit;
    logic [DATA_W-1:0] pad_data [LEAVES];

    // Heap layout: root at 1, children of n at 2n and 2n+1, leaves from LEAVES
    logic [NODES-1:1]  hit_reg;
    logic [PW-1:0]     pos_reg  [NODES-1:1];
    logic [DATA_W-1:0] data_reg [NODES-1:1];

    // Pad the leaf row to a power of two
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_pad
        if (j < DEPTH)
        begin : g_real
            assign pad_hit[j]  = leaf_hit[j];
            assign pad_data[j] = leaf_data[j];
        end
        else
        begin : g_fill
            assign pad_hit[j]  = 1'b0;
            assign pad_data[j] = '0;
        end
    end

    // One level per cycle; the lower index wins
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            hit_reg[LEAVES + j]  <= pad_hit[j];
            pos_reg[LEAVES + j]  <= PW'(j);
            data_reg[LEAVES + j] <= pad_data[j];
        end
        for (int n = 1; n < LEAVES; n++)
        begin
            if (hit_reg[2 * n])
            begin
                hit_reg[n]  <= 1'b1;
                pos_reg[n]  <= pos_reg[2 * n];
                data_reg[n] <= data_reg[2 * n];
            end
            else
            begin
                hit_reg[n]  <= hit_reg[2 * n + 1];
                pos_reg[n]  <= pos_reg[2 * n + 1];
                data_reg[n] <= data_reg[2 * n + 1];
            end
        end
    end

    assign root_hit  = hit_reg[1];
    assign root_pos  = pos_reg[1];
    assign root_data = data_reg[1];

endmodule

// ===== rtl/core/bounded_array_deque_engine_core.sv =====
// Push, pop and unknown requests give their result in the cycle after acceptance.
// Get and find wait in the search state for the registered priority tree that
// reduces the per-cell match flags to the lowest hit.
// Throughput: one push or pop request per cycle; a get or find takes no new request
// until its result is presented. A result held by m_tready stalls the next request.
// Reset clears the element count and the result valid; element cells are not reset
// and no clearing pass is needed.
module bounded_array_deque_engine_core #(
    parameter int DEPTH = badq_pkg::BADQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], index[39:32]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // read_value[31:0], found_position[40:32],
                                   // element_count[49:41], zero[55:50]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import badq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(PW + 2);
    localparam logic [TW-1:0] SEARCH_LAST = TW'(PW + 1);

    // Request fields
    logic [DATA_W-1:0] in_value;
    logic [IDX_W-1:0]  in_index;
    req_t              req;
    logic              accept;
    logic              full;
    logic              empty;
    logic              push_front;
    logic              push_back;
    logic              pop_front;

    // Control and payload registers
    state_t            state_reg, state_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              find_reg, find_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ECNT_W-1:0] ecount_reg, ecount_next;

    // Chain and tree
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_match;
    logic [DEPTH-1:0]  leaf_hit;
    logic              root_hit;
    logic [PW-1:0]     root_pos;
    logic [DATA_W-1:0] root_data;

    assign in_value = s_tdata[31:0];
    assign in_index = s_tdata[39:32];
    assign req      = req_t'(s_tuser);

    // Take a request when idle and the result register is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign push_front = accept && (req == REQ_PUSH_FRONT) && !full;
    assign push_back  = accept && (req == REQ_PUSH_BACK) && !full;
    assign pop_front  = accept && (req == REQ_POP_FRONT) && !empty;

    // Row of element cells with their leaf match flags
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t        ctrl;
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;

        assign ctrl.load       = push_back && (count_reg == CW'(i));
        assign ctrl.shift_up   = push_front;
        assign ctrl.shift_down = pop_front;

        if (i == 0)
        begin : g_head
            assign prev_d = in_value;
        end
        else
        begin : g_body
            assign prev_d = cell_data[i - 1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = cell_data[i];
        end
        else
        begin : g_link
            assign next_d = cell_data[i + 1];
        end

        badq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .ins_value (in_value),
            .prev_data (prev_d),
            .next_data (next_d),
            .key       (key_reg),
            .data      (cell_data[i]),
            .match     (cell_match[i])
        );

        assign leaf_hit[i] = (CW'(i) < count_reg) &&
                             (find_reg ? cell_match[i] : (32'(idx_reg) == 32'(i)));
    end

    badq_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .clk       (clk),
        .leaf_hit  (leaf_hit),
        .leaf_data (cell_data),
        .root_hit  (root_hit),
        .root_pos  (root_pos),
        .root_data (root_data)
    );

    // Sequencer: next state, count and result
    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        count_next     = count_reg;
        find_next      = find_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        rd_next        = rd_reg;
        pos_next       = pos_reg;
        ecount_next    = ecount_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next    = STAT_OK;
                    rd_next        = '0;
                    pos_next       = '0;
                    out_valid_next = 1'b1;
                    unique case (req) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_GET, REQ_FIND:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = ST_SEARCH;
                            tick_next      = '0;
                            find_next      = (req == REQ_FIND);
                            key_next       = in_value;
                            idx_next       = in_index;
                        end
                        REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    ecount_next = ECNT_W'(count_next);
                end
            end
            ST_SEARCH:
            begin
                tick_next = tick_reg + 1'b1;
                if (tick_reg == SEARCH_LAST)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    ecount_next    = ECNT_W'(count_reg);
                    rd_next        = '0;
                    pos_next       = '0;
                    status_next    = STAT_OK;
                    if (find_reg)
                    begin
                        pos_next = root_hit ? POS_W'(root_pos) : '1;
                    end
                    else if (root_hit)
                    begin
                        rd_next = root_data;
                    end
                    else
                    begin
                        status_next = STAT_RANGE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        tick_reg   <= tick_next;
        find_reg   <= find_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        pos_reg    <= pos_next;
        ecount_reg <= ecount_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, ecount_reg, pos_reg, rd_reg};
    assign m_tuser  = status_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above capacity");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((req == REQ_GET) || (req == REQ_FIND)) |=>
            (state_reg == ST_SEARCH) && !s_tready && !m_tvalid)
        else $error("lookup did not enter search");

    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) && (tick_reg == SEARCH_LAST) |=>
            (state_reg == ST_IDLE) && m_tvalid)
        else $error("lookup result not presented");

    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |=> $stable(count_reg))
        else $error("list changed during search");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_back || push_front |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

endmodule
